FILE: rtl/format_spec_parser_unit_assert.svh
// Assertion macros for the conversion specification parser.
// Included by RTL files that carry concurrent checks; needs no other file.
`ifndef FORMAT_SPEC_PARSER_UNIT_ASSERT_SVH
`define FORMAT_SPEC_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsp assertion failed");

`endif

FILE: rtl/fsp_pkg.sv
// Package for the conversion specification parser: phase enum, state and
// result structs, character codes and the saturating decimal accumulate.
// No dependencies.
`default_nettype none

package fsp_pkg;

    localparam logic [30:0] LIMIT31 = 31'h7FFF_FFFF;

    // Character codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    // Flag bit positions
    localparam int FLAG_MINUS = 0;
    localparam int FLAG_ZERO  = 1;
    localparam int FLAG_ALT   = 2;
    localparam int FLAG_SPACE = 3;
    localparam int FLAG_PLUS  = 4;

    typedef enum logic [1:0] {
        PH_MAIN  = 2'd0,
        PH_WIDTH = 2'd1,
        PH_DOT   = 2'd2,
        PH_PREC  = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [4:0]  flags;
        logic [30:0] width;
        logic [30:0] prec;
        logic        sign;
        logic        seen;
    } t_spec_state;

    typedef struct packed {
        logic [4:0]  flag_bits;
        logic [30:0] width_out;
        logic [30:0] precision_out;
        logic        precision_negative;
        logic        precision_given;
        logic [7:0]  conversion;
        logic        consumed;
        logic        spec_error;
    } t_spec_result;

    // acc * 10 + digit, saturated at LIMIT31
    function automatic logic [30:0] acc_digit(input logic [30:0] acc, input logic [7:0] c);
        logic [34:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, c[3:0]};
        return (v > {4'b0, LIMIT31}) ? LIMIT31 : v[30:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_conv(input logic [7:0] c);
        return (c == CH_C) || (c == CH_S) || (c == CH_P) || (c == CH_D) ||
               (c == CH_I) || (c == CH_U) || (c == CH_X_LO) || (c == CH_X_UP);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fsp_step.sv
// Per-character update of the specification parser: next state and the
// optional result for one character. Depends on fsp_pkg.
`default_nettype none

module fsp_step
    import fsp_pkg::*;
(
    input  wire t_spec_state  i_state,
    input  wire logic [7:0]   i_ch,
    input  wire logic         i_start_spec,
    input  wire logic [30:0]  i_printed_count,
    output t_spec_state       o_state,
    output logic              o_emit,
    output t_spec_result      o_result
);

    t_spec_state st;
    logic        dig;
    logic        one_nine;
    logic        sign_ch;
    logic [4:0]  flag_bit;
    logic [31:0] ovf_sum;
    logic        width_ovf;
    logic        go_main;
    logic        main_emit;
    logic        conv_hit;

    // Clear state ahead of the character when a new spec starts
    assign st = i_start_spec ? '0 : i_state;

    // Decode the character
    assign dig      = is_digit(i_ch);
    assign one_nine = (i_ch >= CH_ONE) && (i_ch <= CH_NINE);
    assign sign_ch  = (i_ch == CH_MINUS) || (i_ch == CH_PLUS);
    assign conv_hit = is_conv(i_ch);

    always_comb begin
        flag_bit = '0;
        flag_bit[FLAG_MINUS] = (i_ch == CH_MINUS);
        flag_bit[FLAG_ZERO]  = (i_ch == CH_ZERO);
        flag_bit[FLAG_ALT]   = (i_ch == CH_HASH);
        flag_bit[FLAG_SPACE] = (i_ch == CH_SPACE);
        flag_bit[FLAG_PLUS]  = (i_ch == CH_PLUS);
    end

    // Width run ends: check width plus printed count against the limit
    assign ovf_sum   = {1'b0, st.width} + {1'b0, i_printed_count};
    assign width_ovf = (st.phase == PH_WIDTH) && !dig && (ovf_sum >= {1'b0, LIMIT31});

    // Character falls through to main-loop handling
    always_comb begin
        case (st.phase)
            PH_MAIN:  go_main = 1'b1;
            PH_WIDTH: go_main = !dig && !width_ovf;
            PH_DOT:   go_main = !one_nine && !sign_ch;
            PH_PREC:  go_main = !dig;
            default:  go_main = 1'b1;
        endcase
    end

    assign main_emit = go_main && (flag_bit == '0) && !one_nine && (i_ch != CH_DOT);

    // Next state
    always_comb begin
        o_state = st;
        case (st.phase)
            PH_WIDTH: begin
                if (dig) begin
                    o_state.width = acc_digit(st.width, i_ch);
                end else if (width_ovf) begin
                    o_state.width = '0;
                    o_state.phase = PH_MAIN;
                end
            end
            PH_DOT: begin
                if (one_nine) begin
                    o_state.seen  = 1'b1;
                    o_state.sign  = 1'b0;
                    o_state.prec  = {27'b0, i_ch[3:0]};
                    o_state.phase = PH_PREC;
                end else if (sign_ch) begin
                    o_state.seen  = 1'b1;
                    o_state.sign  = (i_ch == CH_MINUS);
                    o_state.prec  = '0;
                    o_state.phase = PH_PREC;
                end
            end
            PH_PREC: begin
                if (dig) begin
                    o_state.prec = acc_digit(st.prec, i_ch);
                end
            end
            default: begin
            end
        endcase
        if (go_main) begin
            if (flag_bit != '0) begin
                o_state.flags = st.flags | flag_bit;
                o_state.phase = PH_MAIN;
            end else if (one_nine) begin
                o_state.width = {27'b0, i_ch[3:0]};
                o_state.phase = PH_WIDTH;
            end else if (i_ch == CH_DOT) begin
                o_state.phase = PH_DOT;
            end else begin
                o_state.phase = PH_MAIN;
            end
        end
    end

    // Result beat
    always_comb begin
        o_emit                      = width_ovf || main_emit;
        o_result.flag_bits          = st.flags;
        o_result.width_out          = width_ovf ? '0 : st.width;
        o_result.precision_out      = st.prec;
        o_result.precision_negative = st.sign;
        o_result.precision_given    = st.seen;
        o_result.conversion         = (!width_ovf && conv_hit) ? i_ch : '0;
        o_result.consumed           = !width_ovf && conv_hit;
        o_result.spec_error         = width_ovf;
    end

endmodule

`default_nettype wire

FILE: rtl/format_spec_parser_unit.sv
// Top level of the printf conversion specification parser: input register,
// parser state, result register. Depends on fsp_pkg, fsp_step and the
// assertion macro header.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one specification
//   character per beat, with i_start_spec set on the first character after
//   the percent sign and i_printed_count for the width overflow check.
//   Output channel (o_out_valid / i_out_ready) carries one result beat when
//   a character ends the specification; other characters give no beat.
//   Result path: a character goes through the input register, then the
//   result register; the beat is taken at an edge with i_out_ready high.
//   Throughput: one character per cycle unless stalled as below; the parser
//   state loop in fsp_step is a compare plus a times-ten add, updated once per character.
//   Stall: while a result waits in the result register, characters that
//   give no result keep flowing; a character that would give a result
//   waits in the input register, and o_in_ready drops only then.
//   Reset: clears the input and result valid flags and the parser state
//   (flags, width, precision and phase back to the main loop).
`default_nettype none
`include "format_spec_parser_unit_assert.svh"

module format_spec_parser_unit
    import fsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_start_spec,
    input  wire logic [30:0] i_printed_count,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [4:0]       o_flag_bits,
    output logic [30:0]      o_width_out,
    output logic [30:0]      o_precision_out,
    output logic             o_precision_negative,
    output logic             o_precision_given,
    output logic [7:0]       o_conversion,
    output logic             o_consumed,
    output logic             o_spec_error
);

    logic         r_s1_valid;
    logic [7:0]   r_s1_ch;
    logic         r_s1_start;
    logic [30:0]  r_s1_pc;
    t_spec_state  r_state;
    logic         r_out_valid;
    t_spec_result r_out;

    t_spec_state  n_state;
    t_spec_result n_out;
    logic         emit;
    logic         out_free;
    logic         s1_fire;
    logic         in_fire;

    fsp_step u_step (
        .i_state         (r_state),
        .i_ch            (r_s1_ch),
        .i_start_spec    (r_s1_start),
        .i_printed_count (r_s1_pc),
        .o_state         (n_state),
        .o_emit          (emit),
        .o_result        (n_out)
    );

    // Handshake control
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && (!emit || out_free);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_ch    <= i_ch;
            r_s1_start <= i_start_spec;
            r_s1_pc    <= i_printed_count;
        end
    end

    // Advance parser state once per processed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    // Result register: load on an emitting character, drop on a taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_flag_bits          = r_out.flag_bits;
    assign o_width_out          = r_out.width_out;
    assign o_precision_out      = r_out.precision_out;
    assign o_precision_negative = r_out.precision_negative;
    assign o_precision_given    = r_out.precision_given;
    assign o_conversion         = r_out.conversion;
    assign o_consumed           = r_out.consumed;
    assign o_spec_error         = r_out.spec_error;

    // Checks
    `FSP_ASSERT_IMPL(a_err_clean, i_clk, i_rst_n, o_out_valid && o_spec_error,
        (o_width_out == '0) && (o_conversion == '0) && !o_consumed)
    `FSP_ASSERT_IMPL(a_consumed_conv, i_clk, i_rst_n, o_out_valid,
        o_consumed == (o_conversion != '0))
    `FSP_ASSERT_IMPL(a_rise_from_emit, i_clk, i_rst_n, $rose(o_out_valid),
        $past(s1_fire && emit))
    `FSP_ASSERT_NEXT(a_main_after_emit, i_clk, i_rst_n, s1_fire && emit,
        r_state.phase == PH_MAIN)

endmodule

`default_nettype wire
